>>> sv/idmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idmu_pkg: shared types and constants of the 64-bit divide/modulo unit
// Opcodes, sequencer states and the control bundle from sequencer to datapath.
// ----------------------------------------------------------------------------
package idmu_pkg;

  localparam int DataW = 64;
  localparam int StepW = 6;
  localparam logic [StepW-1:0] LastStep = 6'd63;

  localparam logic [1:0] OP_UDIV = 2'd0;
  localparam logic [1:0] OP_SDIV = 2'd1;
  localparam logic [1:0] OP_UREM = 2'd2;
  localparam logic [1:0] OP_SREM = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_N,
    ST_ABS_D,
    ST_DIV,
    ST_FIX
  } state_t;

  typedef struct packed {
    logic idle;
    logic abs_n;
    logic abs_d;
    logic div_step;
    logic fix;
  } ctrl_t;

endpackage

>>> sv/idmu_sub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idmu_sub: shared 65-bit subtractor
// Serves operand negation, every restoring division step and the sign fix-up.
// ----------------------------------------------------------------------------
module idmu_sub import idmu_pkg::*; (
  input  logic [DataW:0] a,
  input  logic [DataW:0] b,
  output logic [DataW:0] diff,
  output logic           borrow
);

  logic [DataW+1:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[DataW:0];
  assign borrow = full[DataW+1];

endmodule

>>> sv/idmu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idmu_ctrl: sequencer of the divide/modulo unit
// Steps through operand magnitudes, 64 division steps and the sign fix-up.
// ----------------------------------------------------------------------------
module idmu_ctrl import idmu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t           state;
  state_t           state_next;
  logic [StepW-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_ABS_N;
      ST_ABS_N: state_next = ST_ABS_D;
      ST_ABS_D: state_next = ST_DIV;
      ST_DIV:   if (step == LastStep) state_next = ST_FIX;
      ST_FIX:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:  ctrl.idle     = 1'b1;
      ST_ABS_N: ctrl.abs_n    = 1'b1;
      ST_ABS_D: ctrl.abs_d    = 1'b1;
      ST_DIV:   ctrl.div_step = 1'b1;
      ST_FIX:   ctrl.fix      = 1'b1;
      default:  ctrl          = '0;
    endcase
  end

endmodule

>>> sv/int64_divide_modulo_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_divide_modulo_unit_core: 64-bit signed/unsigned divide and remainder
// Radix-2 restoring divider around one shared 65-bit subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation: s_tuser holds the opcode (unsigned quotient,
//   signed quotient, unsigned remainder, signed remainder), s_tdata the
//   dividend and divisor. m_* returns the 64-bit result.
//   The sequencer takes one step each for dividend and divisor magnitude,
//   64 division steps (one quotient bit per cycle through the shared
//   subtractor) and one sign fix-up step that loads m_tdata and m_tvalid.
//   A new operation is taken only after the previous one has finished;
//   s_tready is high only while the sequencer is idle.
//   The result sits in an output register, so a new operation is accepted
//   while the previous result waits. If the receiver stalls, the fix-up
//   cycle holds until the output register frees up.
//   Division by zero gives an all-ones quotient magnitude and a remainder
//   equal to the dividend; the most negative value over -1 wraps.
//   Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module int64_divide_modulo_unit_core import idmu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // dividend[63:0], divisor[127:64]
  input  logic [1:0]   s_tuser,   // opcode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata    // result[63:0]
);

  ctrl_t            ctrl;
  logic             start;
  logic             out_free;
  logic [1:0]       op;
  logic             nneg;
  logic             dneg;
  logic [DataW-1:0] num;
  logic [DataW-1:0] den;
  logic [DataW-1:0] rem;
  logic [DataW:0]   sub_a;
  logic [DataW:0]   sub_b;
  logic [DataW:0]   diff;
  logic             borrow;
  logic [DataW-1:0] res_sel;
  logic             res_neg;

  assign s_tready = ctrl.idle & ~rst;
  assign start    = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  idmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign res_sel = op[1] ? rem : num;

  always_comb begin
    case (op)
      OP_SDIV: res_neg = nneg ^ dneg;
      OP_SREM: res_neg = nneg;
      default: res_neg = 1'b0;
    endcase
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    if (ctrl.abs_n) begin
      sub_b = {1'b0, num};
    end else if (ctrl.abs_d) begin
      sub_b = {1'b0, den};
    end else if (ctrl.div_step) begin
      sub_a = {rem, num[DataW-1]};
      sub_b = {1'b0, den};
    end else begin
      sub_b = {1'b0, res_sel};
    end
  end

  idmu_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (diff),
    .borrow (borrow)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= s_tuser;
      num  <= s_tdata[63:0];
      den  <= s_tdata[127:64];
      nneg <= s_tdata[63];
      dneg <= s_tdata[127];
      rem  <= '0;
    end
    if (ctrl.abs_n && op[0] && nneg) begin
      num <= diff[DataW-1:0];
    end
    if (ctrl.abs_d && op[0] && dneg) begin
      den <= diff[DataW-1:0];
    end
    if (ctrl.div_step) begin
      rem <= borrow ? sub_a[DataW-1:0] : diff[DataW-1:0];
      num <= {num[DataW-2:0], ~borrow};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.fix && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fix && out_free) begin
      m_tdata <= res_neg ? diff[DataW-1:0] : res_sel;
    end
  end

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot({ctrl.idle, ctrl.abs_n, ctrl.abs_d, ctrl.div_step, ctrl.fix}))
    else $error("sequencer phases overlap");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    start |=> ctrl.abs_n)
    else $error("accepted transaction did not start magnitude phase");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.div_step |=> (den == '0) || (rem < den))
    else $error("partial remainder not below divisor");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.fix && out_free |=> m_tvalid && ctrl.idle)
    else $error("result not presented after fix-up");

endmodule
